/* hw/rtl/edsp_pkg.sv */
// Shared types, constants and arithmetic helpers of the error diffusion seed picker.
package edsp_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int ERR_W             = 21;
   localparam int ROW_W             = 12;
   localparam int CSR_DATA_W        = 13;
   localparam int WIDTH_REG_W       = 12;
   localparam int HEIGHT_REG_W      = 13;
   localparam int MAX_HEIGHT        = 4096;
   localparam int RESET_WIDTH       = 640;
   localparam int RESET_HEIGHT      = 480;

   typedef logic signed [ERR_W-1:0] err_type;

   localparam err_type ERR_MAX = 21'sd1048575;
   localparam err_type ERR_MIN = -21'sd1048576;
   localparam err_type HALF_Q  = 21'sd16384;
   localparam err_type ONE_Q   = 21'sd32768;

   localparam logic [2:0] SHARE_RIGHT      = 3'd7;
   localparam logic [2:0] SHARE_BELOW_LEFT = 3'd3;
   localparam logic [2:0] SHARE_BELOW      = 3'd5;
   localparam logic [2:0] SHARE_BELOW_RIGHT = 3'd1;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] density_sample;
      logic [15:0] pixel_radius;
   } req_type;

   typedef struct packed {
      logic [10:0] seed_x;
      logic [11:0] seed_y;
      logic [15:0] seed_radius;
   } rsp_type;

   // Position flags of the pixel in the execute stage.
   typedef struct packed {
      logic col_zero;
      logic col_one;
      logic last_col;
      logic last_row;
      logic row_zero;
   } stage_flags_type;

   // What one executed pixel asks of the row buffer and the result register.
   typedef struct packed {
      logic    seed;
      logic    near_wr_en;
      err_type near_data;
      logic    far_wr_en;
      err_type far_data;
   } core_out_type;

   function automatic err_type sat_add(input err_type a, input err_type b);
      logic [ERR_W:0] s;
      s = {a[ERR_W-1], a} + {b[ERR_W-1], b};
      if (s[ERR_W] != s[ERR_W-1]) begin
         return s[ERR_W] ? ERR_MIN : ERR_MAX;
      end
      return err_type'(s[ERR_W-1:0]);
   endfunction

   // floor((k * e + 8) / 16): round to nearest, ties toward plus infinity
   function automatic err_type share(input err_type e, input logic [2:0] k);
      logic signed [ERR_W+3:0] t;
      t = (ERR_W+4)'(e) * (ERR_W+4)'(signed'({1'b0, k}));
      t = t + (ERR_W+4)'(8);
      return err_type'(t >>> 4);
   endfunction

endpackage

/* hw/rtl/edsp_row_mem.sv */
// Row error buffer: one write port, one registered read port.
module edsp_row_mem #(
   parameter int DEPTH = edsp_pkg::MAX_WIDTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  edsp_pkg::err_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output edsp_pkg::err_type rd_data
);

   logic [edsp_pkg::ERR_W-1:0] mem_ff [DEPTH];
   logic [edsp_pkg::ERR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = edsp_pkg::err_type'(rd_data_ff);

endmodule

/* hw/rtl/edsp_diffuse_core.sv */
// Diffusion datapath: threshold, error shares and the running error registers.
module edsp_diffuse_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  edsp_pkg::stage_flags_type flags,
   input  logic [15:0]               density_sample,
   input  edsp_pkg::err_type         above_raw,
   output edsp_pkg::core_out_type    result
);

   edsp_pkg::err_type right_ff, right_in;
   edsp_pkg::err_type near_ff, near_in;
   edsp_pkg::err_type far_ff, far_in;
   edsp_pkg::err_type hold_ff, hold_in;
   edsp_pkg::err_type carry_ff, carry_in;

   edsp_pkg::err_type d_q, above, carry, base, pix, err;
   logic              hit;

   always_comb begin
      d_q   = edsp_pkg::err_type'({5'b0, density_sample});
      above = flags.row_zero ? '0 : above_raw;
      carry = flags.row_zero ? '0 : carry_ff;
      base  = edsp_pkg::sat_add(d_q, above);
      pix   = edsp_pkg::sat_add(base, right_ff);
      if (flags.col_one) begin
         pix = edsp_pkg::sat_add(pix, hold_ff);
      end
      hit = pix >= edsp_pkg::HALF_Q;
      err = hit ? pix - edsp_pkg::ONE_Q : pix;

      right_in = right_ff;
      near_in  = near_ff;
      far_in   = far_ff;
      hold_in  = hold_ff;
      carry_in = carry_ff;
      result   = '0;

      if (go && !flags.last_row) begin
         priority if (flags.col_zero) begin
            hold_in  = edsp_pkg::sat_add(base, carry);
            right_in = '0;
            near_in  = '0;
            far_in   = '0;
         end else if (flags.last_col) begin
            // drain both partial sums into the row buffer
            carry_in          = edsp_pkg::sat_add(base, right_ff);
            result.near_wr_en = 1'b1;
            result.near_data  = near_ff;
            result.far_wr_en  = 1'b1;
            result.far_data   = far_ff;
         end else begin
            result.seed       = hit;
            right_in          = edsp_pkg::share(err, edsp_pkg::SHARE_RIGHT);
            result.near_wr_en = 1'b1;
            result.near_data  = edsp_pkg::sat_add(near_ff,
                                   edsp_pkg::share(err, edsp_pkg::SHARE_BELOW_LEFT));
            near_in           = edsp_pkg::sat_add(far_ff,
                                   edsp_pkg::share(err, edsp_pkg::SHARE_BELOW));
            far_in            = edsp_pkg::share(err, edsp_pkg::SHARE_BELOW_RIGHT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff <= '0;
         near_ff  <= '0;
         far_ff   <= '0;
         hold_ff  <= '0;
         carry_ff <= '0;
      end else begin
         right_ff <= right_in;
         near_ff  <= near_in;
         far_ff   <= far_in;
         hold_ff  <= hold_in;
         carry_ff <= carry_in;
      end
   end

endmodule

/* hw/rtl/error_diffusion_seed_picker_unit.sv */
// Top level of the error diffusion seed picker: control, row buffer and result register.
//
// Takes density pixels in raster order, one request per clock unless the
// clearing pass or a stalled rsp_ channel holds them, and runs Floyd-Steinberg
// error diffusion on them; every interior pixel whose value reaches 0.5
// yields one seed (column, row, radius) on the rsp_ channel. A request is
// registered together with the row buffer entry for its column, and a seed
// lands in the result register at the end of the cycle in which its pixel
// executes. The sustained rate is one pixel per clock, which the single write
// port of the row buffer keeps up with: the last column drains two partial
// sums, and the second one is written in the following cycle, when column
// zero of the next row writes nothing. Every pixel, seed or not, executes
// only while the result register is free or being emptied, so a stalled rsp_
// channel holds the pipe after one more request.
// After reset the row buffer is zeroed by a clearing pass over its MAX_WIDTH
// entries, during which req_ready stays low; csr_ writes are taken throughout.
// Column zero is never thresholded and is folded into column one, the last column
// carries into column zero of the next row, the last row emits nothing, and
// row zero of every frame sees zero error from above. Width and height
// writes are clamped to 3..MAX_WIDTH and 2..4096 and should be made only
// while the block is idle.
module error_diffusion_seed_picker_unit #(
   parameter int MAX_WIDTH = edsp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  edsp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output edsp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [edsp_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = edsp_pkg::ROW_W;
   localparam logic [CW-1:0] RESET_LAST_COL =
      CW'((edsp_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : edsp_pkg::RESET_WIDTH - 1);
   localparam logic [RW-1:0] RESET_LAST_ROW = RW'(edsp_pkg::RESET_HEIGHT - 1);
   localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_WIDTH - 1);

   // Configuration: hold the clamped last column and last row indexes.
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [RW-1:0] last_row_ff, last_row_in;
   logic [edsp_pkg::WIDTH_REG_W-1:0]  width_val;
   logic [edsp_pkg::HEIGHT_REG_W-1:0] height_val;

   always_comb begin
      width_val   = csr_wr_data[edsp_pkg::WIDTH_REG_W-1:0];
      height_val  = csr_wr_data[edsp_pkg::HEIGHT_REG_W-1:0];
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_wr_en) begin
         unique case (edsp_pkg::csr_index_type'(csr_index))
            edsp_pkg::CSR_IMAGE_WIDTH: begin
               priority if (width_val < 12'd3) begin
                  last_col_in = CW'(2);
               end else if (32'(width_val) > MAX_WIDTH) begin
                  last_col_in = CW'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = CW'(width_val - 12'd1);
               end
            end
            edsp_pkg::CSR_IMAGE_HEIGHT: begin
               priority if (height_val < 13'd2) begin
                  last_row_in = RW'(1);
               end else if (32'(height_val) > edsp_pkg::MAX_HEIGHT) begin
                  last_row_in = RW'(edsp_pkg::MAX_HEIGHT - 1);
               end else begin
                  last_row_in = RW'(height_val - 13'd1);
               end
            end
            default: begin
               last_col_in = last_col_ff;
            end
         endcase
      end
   end

   // Clearing pass over the row buffer after reset.
   logic          clr_busy_ff, clr_busy_in;
   logic [CW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + CW'(1);
         if (clr_addr_ff == CLEAR_LAST) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // Raster position of the next request and the execute stage.
   logic                      accept, exec_go;
   logic [CW-1:0]             col_ff, col_in;
   logic [RW-1:0]             row_ff, row_in;
   logic                      acc_last_col, acc_last_row;
   logic [CW-1:0]             rd_addr;
   logic                      stg_vld_ff, stg_vld_in;
   edsp_pkg::req_type         stg_req_ff;
   logic [CW-1:0]             stg_col_ff;
   logic [RW-1:0]             stg_row_ff;
   logic [CW-1:0]             stg_addr_ff;
   edsp_pkg::stage_flags_type stg_flags_ff, acc_flags;
   edsp_pkg::core_out_type    core_out;
   edsp_pkg::err_type         above_raw;

   assign exec_go   = stg_vld_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !clr_busy_ff && (!stg_vld_ff || exec_go);
   assign accept    = req_valid && req_ready;

   always_comb begin
      acc_last_col       = col_ff >= last_col_ff;
      acc_last_row       = row_ff >= last_row_ff;
      acc_flags.col_zero = col_ff == '0;
      acc_flags.col_one  = col_ff == CW'(1);
      acc_flags.last_col = acc_last_col;
      acc_flags.last_row = acc_last_row;
      acc_flags.row_zero = row_ff == '0;
      // past the last column, use the last column's entry
      rd_addr = acc_last_col ? last_col_ff : col_ff;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (acc_last_col) begin
            col_in = '0;
            row_in = acc_last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      stg_vld_in = stg_vld_ff;
      if (accept) begin
         stg_vld_in = 1'b1;
      end else if (exec_go) begin
         stg_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_req_ff   <= req_data;
         stg_col_ff   <= col_ff;
         stg_row_ff   <= row_ff;
         stg_addr_ff  <= rd_addr;
         stg_flags_ff <= acc_flags;
      end
   end

   edsp_diffuse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .go             (exec_go),
      .flags          (stg_flags_ff),
      .density_sample (stg_req_ff.density_sample),
      .above_raw      (above_raw),
      .result         (core_out)
   );

   // Row buffer write port: clearing first, then the current pixel, then the
   // far partial sum deferred from the last column.
   logic              pend_vld_ff, pend_vld_in;
   logic [CW-1:0]     pend_addr_ff;
   edsp_pkg::err_type pend_data_ff;
   logic              wr_en;
   logic [CW-1:0]     wr_addr;
   edsp_pkg::err_type wr_data;
   logic              near_wr;

   always_comb begin
      near_wr     = exec_go && core_out.near_wr_en;
      pend_vld_in = pend_vld_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      priority if (clr_busy_ff) begin
         wr_en = 1'b1;
      end else if (near_wr) begin
         wr_en   = 1'b1;
         wr_addr = stg_addr_ff - CW'(1);
         wr_data = core_out.near_data;
      end else if (pend_vld_ff) begin
         wr_en       = 1'b1;
         wr_addr     = pend_addr_ff;
         wr_data     = pend_data_ff;
         pend_vld_in = 1'b0;
      end else begin
         wr_en = 1'b0;
      end
      if (exec_go && core_out.far_wr_en) begin
         pend_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && core_out.far_wr_en) begin
         pend_addr_ff <= stg_addr_ff;
         pend_data_ff <= core_out.far_data;
      end
   end

   edsp_row_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (above_raw)
   );

   // Result register: load a seed, drop it once taken.
   logic              rsp_vld_ff, rsp_vld_in;
   edsp_pkg::rsp_type rsp_data_ff;

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (exec_go && core_out.seed) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && core_out.seed) begin
         rsp_data_ff.seed_x      <= 11'(stg_col_ff);
         rsp_data_ff.seed_y      <= stg_row_ff;
         rsp_data_ff.seed_radius <= stg_req_ff.pixel_radius;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= RESET_LAST_COL;
         last_row_ff <= RESET_LAST_ROW;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         stg_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         stg_vld_ff  <= stg_vld_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // The deferred far write must never meet a pixel write in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> !near_wr)
      else $error("deferred row write collides with a pixel write");

   // A new seed only shows up after a pixel was executed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(exec_go))
      else $error("seed appeared without an executed pixel");

   // The clearing pass runs once after reset and never restarts.
   assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("row buffer clearing restarted");

endmodule

/* verif/error_diffusion_seed_picker_unit_tb.sv */
// Self-checking testbench of the error diffusion seed picker with its own diffusion predictor.
`timescale 1ns / 1ps

module error_diffusion_seed_picker_unit_tb;

   // Q5.15 limits, threshold and the unit taken off by a seed
   localparam int Q_TOP      = 1048575;
   localparam int Q_BOTTOM   = -1048576;
   localparam int SEED_LEVEL = 16384;
   localparam int SEED_UNIT  = 32768;

   // Floyd-Steinberg weights in sixteenths
   localparam int WEIGHT_RIGHT       = 7;
   localparam int WEIGHT_BELOW_LEFT  = 3;
   localparam int WEIGHT_BELOW       = 5;
   localparam int WEIGHT_BELOW_RIGHT = 1;

   localparam int MIN_WIDTH     = 3;
   localparam int MIN_HEIGHT    = 2;
   localparam int SETTLE_CYCLES = 10;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_PIXELS = 1100;
   localparam int CFG_W         = edsp_pkg::CSR_DATA_W;

   // Opening script: pixels and register writes; a typed row carries its own expectation
   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_SET_WIDTH,
      STEP_SET_HEIGHT
   } step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [15:0]   value;
      logic [15:0]   radius;
      logic          typed;
      logic          fires;
      logic [10:0]   seed_x;
      logic [11:0]   seed_y;
   } script_step_type;

   localparam int SCRIPT_LEN = 29;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   edsp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   edsp_pkg::rsp_type rsp_data;
   logic              csr_wr_en = 1'b0;
   logic              csr_index = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   int unsigned req_idle_pct = 27;
   int unsigned rsp_idle_pct = 87;
   int unsigned mismatch_count = 0;

   // Seeds the predictor has promised, oldest first
   edsp_pkg::rsp_type pending_seeds [$];

   // Predictor copy of the registers and of the diffusion state
   int unsigned cfg_width  = edsp_pkg::RESET_WIDTH;
   int unsigned cfg_height = edsp_pkg::RESET_HEIGHT;
   int          error_below [edsp_pkg::MAX_WIDTH_DEFAULT];
   int          error_right;
   int          partial_near;
   int          partial_far;
   int          column_zero_value;
   int          wrap_carry;
   int unsigned col_pos;
   int unsigned row_pos;

   //   kind             value     radius    typed fires  x       y
   script_step_type opening_script [SCRIPT_LEN] = '{
      // reset size 640 x 480: column zero only collects, column one sees its value
      '{STEP_PIXEL,      16'hFFFF, 16'h1234, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h0000, 16'hABCD, 1'b1, 1'b1, 11'd1, 12'd0},
      '{STEP_PIXEL,      16'h0000, 16'h0001, 1'b0, 1'b0, 11'd0, 12'd0},
      // shrink to the smallest frame while standing at column three of row zero
      '{STEP_SET_WIDTH,  16'h0000, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_SET_HEIGHT, 16'h0000, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      // beyond the last column: acts as the last column, never fires
      '{STEP_PIXEL,      16'h8000, 16'h5555, 1'b1, 1'b0, 11'd0, 12'd0},
      // last row: silent
      '{STEP_PIXEL,      16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hFFFF, 16'h0000, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hFFFF, 16'h8001, 1'b1, 1'b0, 11'd0, 12'd0},
      // fresh frame: exactly one half fires
      '{STEP_PIXEL,      16'h2000, 16'h0000, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h2000, 16'hFFFF, 1'b1, 1'b1, 11'd1, 12'd0},
      '{STEP_PIXEL,      16'h0000, 16'h7FFF, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h1234, 16'hAAAA, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h5678, 16'h5555, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h9ABC, 16'h0F0F, 1'b1, 1'b0, 11'd0, 12'd0},
      // fresh frame: one step under the threshold stays quiet
      '{STEP_PIXEL,      16'h2000, 16'hF0F0, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h1FFF, 16'h1357, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hFFFF, 16'h2468, 1'b1, 1'b0, 11'd0, 12'd0},
      // widest and tallest (clamped) while at row one, column zero
      '{STEP_SET_WIDTH,  16'h0FFF, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_SET_HEIGHT, 16'h1FFF, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hFFFF, 16'h00FF, 1'b1, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hFFFF, 16'hFF00, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h0000, 16'h3C3C, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h7FFF, 16'hC3C3, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h8000, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'h4000, 16'hFFFF, 1'b0, 1'b0, 11'd0, 12'd0},
      // cut the row short mid-frame: column six now acts as the last column
      '{STEP_SET_WIDTH,  16'h0004, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_SET_HEIGHT, 16'h0003, 16'h0000, 1'b0, 1'b0, 11'd0, 12'd0},
      '{STEP_PIXEL,      16'hC000, 16'h1111, 1'b0, 1'b0, 11'd0, 12'd0}
   };

   error_diffusion_seed_picker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturating Q5.15 add
   function automatic int q_add(input int a, input int b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > Q_TOP) return Q_TOP;
      if (s < Q_BOTTOM) return Q_BOTTOM;
      return int'(s);
   endfunction

   // floor((k * e + 8) / 16): the arithmetic shift of a signed value floors
   function automatic int error_share(input int e, input int k);
      longint t;
      t = longint'(k) * longint'(e) + 64'sd8;
      return int'(t >>> 4);
   endfunction

   // Advance the predictor by one pixel; return 1 and fill seed when the pixel fires
   function automatic bit diffuse_pixel(input edsp_pkg::req_type px,
                                        output edsp_pkg::rsp_type seed);
      int unsigned w;
      int unsigned h;
      int          d;
      int          above;
      int          v;
      bit          last_col;
      bit          last_row;
      bit          fired;
      w = cfg_width;
      h = cfg_height;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > edsp_pkg::MAX_WIDTH_DEFAULT) w = edsp_pkg::MAX_WIDTH_DEFAULT;
      if (h < MIN_HEIGHT) h = MIN_HEIGHT;
      if (h > edsp_pkg::MAX_HEIGHT) h = edsp_pkg::MAX_HEIGHT;
      d = int'(px.density_sample);
      seed = '0;
      fired = 1'b0;
      last_col = col_pos >= w - 1;
      last_row = row_pos >= h - 1;

      if (!last_row) begin
         if (col_pos == 0) begin
            // row zero of a frame sees neither error from above nor a carry
            above = (row_pos == 0) ? 0 : error_below[0];
            column_zero_value = q_add(q_add(d, above), (row_pos == 0) ? 0 : wrap_carry);
            error_right  = 0;
            partial_near = 0;
            partial_far  = 0;
         end else if (last_col) begin
            // hand the value to the next row and flush both partial sums
            above = (row_pos == 0) ? 0 : error_below[w - 1];
            wrap_carry = q_add(q_add(d, above), error_right);
            error_below[w - 2] = partial_near;
            error_below[w - 1] = partial_far;
         end else begin
            above = (row_pos == 0) ? 0 : error_below[col_pos];
            v = q_add(q_add(d, above), error_right);
            if (col_pos == 1) v = q_add(v, column_zero_value);
            if (v >= SEED_LEVEL) begin
               v -= SEED_UNIT;
               fired = 1'b1;
               seed.seed_x      = 11'(col_pos);
               seed.seed_y      = 12'(row_pos);
               seed.seed_radius = px.pixel_radius;
            end
            error_right = error_share(v, WEIGHT_RIGHT);
            error_below[col_pos - 1] = q_add(partial_near, error_share(v, WEIGHT_BELOW_LEFT));
            partial_near = q_add(partial_far, error_share(v, WEIGHT_BELOW));
            partial_far  = error_share(v, WEIGHT_BELOW_RIGHT);
         end
      end

      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      return fired;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR %0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Append one promised seed behind the others
   task automatic expect_seed(input edsp_pkg::rsp_type seed);
      pending_seeds = {pending_seeds, seed};
   endtask

   // Drop valid, wait until every promised seed is out, then let the pipe run dry
   task automatic settle_pipe();
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (pending_seeds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register on an idle block; the caller's next step lowers the enable
   task automatic write_csr(input edsp_pkg::csr_index_type idx, input logic [CFG_W-1:0] value);
      settle_pipe();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == edsp_pkg::CSR_IMAGE_WIDTH) cfg_width = value[edsp_pkg::WIDTH_REG_W-1:0];
      else cfg_height = value;
   endtask

   // Offer one request, hold it until taken, then record what it should produce
   task automatic send_pixel(input edsp_pkg::req_type px, input bit typed, input bit fires,
                             input edsp_pkg::rsp_type typed_seed);
      edsp_pkg::rsp_type seed;
      bit                predicted;
      csr_wr_en <= 1'b0;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // the predictor always advances; typed rows override its verdict
      predicted = diffuse_pixel(px, seed);
      if (typed) begin
         predicted = fires;
         seed = typed_seed;
      end
      if (predicted) expect_seed(seed);
   endtask

   // Density styles: full range, mostly quiet, mostly firing, threshold corners
   function automatic logic [15:0] pick_density(input int unsigned style);
      unique case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(16'h3FFF, 0));
         2: return 16'($urandom_range(16'hFFFF, 16'hC000));
         default: begin
            unique case ($urandom_range(4))
               0: return 16'h0000;
               1: return 16'h3FFF;
               2: return 16'h4000;
               3: return 16'hFFFF;
               default: return 16'($urandom);
            endcase
         end
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_width();
      unique case ($urandom_range(9))
         0: return CFG_W'($urandom_range(2, 0));
         1: return $urandom_range(1) ? CFG_W'(edsp_pkg::MAX_WIDTH_DEFAULT) : CFG_W'($urandom);
         2: return CFG_W'($urandom_range(64, 11));
         default: return CFG_W'($urandom_range(10, 3));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_height();
      unique case ($urandom_range(9))
         0: return CFG_W'($urandom_range(1, 0));
         1: return $urandom_range(1) ? CFG_W'(edsp_pkg::MAX_HEIGHT) : CFG_W'($urandom);
         2: return CFG_W'($urandom_range(40, 7));
         default: return CFG_W'($urandom_range(6, 2));
      endcase
   endfunction

   // Receiver: stall at the rate of the current regime
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Compare every taken seed against the oldest promised one
   always @(posedge clock) begin : seed_check
      edsp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_seeds.size() == 0) begin
            report_mismatch("seed with none expected", rsp_data, 0);
         end else begin
            want = pending_seeds.pop_front();
            if (rsp_data.seed_x !== want.seed_x)
               report_mismatch("seed_x", rsp_data.seed_x, want.seed_x);
            if (rsp_data.seed_y !== want.seed_y)
               report_mismatch("seed_y", rsp_data.seed_y, want.seed_y);
            if (rsp_data.seed_radius !== want.seed_radius)
               report_mismatch("seed_radius", rsp_data.seed_radius, want.seed_radius);
         end
      end
   end

   initial begin : stimulus
      script_step_type   step;
      edsp_pkg::req_type px;
      int unsigned       random_done;
      int unsigned       style;
      int unsigned       burst;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the opening script; the clearing pass after reset is absorbed by req_ready
      foreach (opening_script[i]) begin
         step = opening_script[i];
         unique case (step.kind)
            STEP_SET_WIDTH:  write_csr(edsp_pkg::CSR_IMAGE_WIDTH, step.value[CFG_W-1:0]);
            STEP_SET_HEIGHT: write_csr(edsp_pkg::CSR_IMAGE_HEIGHT, step.value[CFG_W-1:0]);
            default: begin
               px.density_sample = step.value;
               px.pixel_radius   = step.radius;
               send_pixel(px, step.typed, step.fires,
                          edsp_pkg::rsp_type'{step.seed_x, step.seed_y, step.radius});
            end
         endcase
      end

      // Random bursts of raster pixels; each burst may resize the frame mid-stream,
      // so positions past the new last column or row get exercised too
      random_done = 0;
      while (random_done < RANDOM_PIXELS) begin
         if (random_done < RANDOM_PIXELS / 3) begin
            req_idle_pct = 27;
            rsp_idle_pct = 87;
         end else if (random_done < 2 * RANDOM_PIXELS / 3) begin
            req_idle_pct = 87;
            rsp_idle_pct = 27;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if ($urandom_range(3) != 0) write_csr(edsp_pkg::CSR_IMAGE_WIDTH, pick_width());
         if ($urandom_range(3) != 0) write_csr(edsp_pkg::CSR_IMAGE_HEIGHT, pick_height());
         style = $urandom_range(3);
         burst = $urandom_range(90, 15);
         repeat (burst) begin
            px.density_sample = pick_density(style);
            px.pixel_radius   = 16'($urandom);
            send_pixel(px, 1'b0, 1'b0, '0);
            random_done++;
         end
      end

      // Drain: wait for the last seed, then give the pipe time to show strays
      req_valid <= 1'b0;
      csr_wr_en <= 1'b0;
      while (pending_seeds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("error_diffusion_seed_picker_unit test passed");
      end else begin
         $display("error_diffusion_seed_picker_unit test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("error_diffusion_seed_picker_unit test failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/edsp_pkg.sv
hw/rtl/edsp_row_mem.sv
hw/rtl/edsp_diffuse_core.sv
hw/rtl/error_diffusion_seed_picker_unit.sv
verif/error_diffusion_seed_picker_unit_tb.sv
